// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with reset masking.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or sequence property, sampled on clk, masked while in reset
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain expression that must hold at every sampled edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	`ASSERT_PROP(lbl, (expr), msg)

`endif

// ----- hw/rtl/stsi_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stsi_pkg
// Shared constants for the sorted table search/insert block.
// ---------------------------------------------------------------------------
package stsi_pkg;

	// default table depth
	localparam int STSI_CAPACITY = 16;

	// width of one stored entry
	localparam int STSI_DATA_W = 32;

	// result field widths
	localparam int STSI_POS_W = 5;

endpackage

// ----- hw/rtl/sorted_table_search_insert.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_table_search_insert
// Sorted signed table with linear search and ordered insert.
// ---------------------------------------------------------------------------
// Keeps up to CAPACITY signed 32-bit values in ascending order in a
// single-port-read, single-port-write RAM, empty after reset. Each request is
// handled on its own: a linear scan reads entries from index 0 at one per
// cycle until the first entry not less than the value, then, for an absent
// value with room left, the larger entries are moved up one place from the
// top down at one per cycle, the value is written and the count raised;
// finally the result is handed to the output register, once any stalled
// earlier result has been taken. Scan and shift go one entry at a time,
// set by the one read and one write port of the table RAM. A new request is
// taken while the previous result still waits on the master side. Each
// request gives one result.
module sorted_table_search_insert import stsi_pkg::*; #(
	parameter int CAPACITY = STSI_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [4:0] position, [9:5] fill_count
	output logic [2:0]  m_tuser    // [0] found, [1] inserted, [2] table_full
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_SHIFT  = 6'b001000,
		ST_WRITE  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [STSI_DATA_W-1:0] value_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       pos_q;
	logic                   rd_pend_q;
	logic [CNT_W-1:0]       sh_q;
	logic                   sh_pend_q;
	logic [IDX_W-1:0]       wr_idx_s1;
	logic                   found_q;
	logic                   full_q;
	logic                   ins_q;
	logic                   m_tvalid_q;
	logic [15:0]            m_tdata_q;
	logic [2:0]             m_tuser_q;

	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [STSI_DATA_W-1:0] rd_data;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [STSI_DATA_W-1:0] wr_data;
	logic [CNT_W:0]         nxt_pos;
	logic                   more_left;
	logic                   key_greater;
	logic                   out_free;
	logic                   out_load;

	assign nxt_pos     = {1'b0, pos_q} + 1'b1;
	assign more_left   = nxt_pos < {1'b0, count_q};
	assign key_greater = $signed(value_q) > $signed(rd_data);
	assign out_free    = !m_tvalid_q || m_tready;
	assign out_load    = (state_q == ST_DONE) && out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// table RAM
	stsi_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = IDX_W'(pos_q);
		wr_en   = 1'b0;
		wr_addr = wr_idx_s1;
		wr_data = rd_data;
		unique case (state_q)
			ST_SEARCH: begin
				// fetch the first entry, then the entry after the one being compared
				if (rd_pend_q) begin
					rd_en   = more_left;
					rd_addr = IDX_W'(nxt_pos);
				end else begin
					rd_en   = (count_q != '0);
					rd_addr = IDX_W'(pos_q);
				end
			end
			ST_SHIFT: begin
				// read j-1 while writing the previous read to j
				rd_en   = sh_q > pos_q;
				rd_addr = IDX_W'(sh_q - 1'b1);
				wr_en   = sh_pend_q;
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(pos_q);
				wr_data = value_q;
			end
			ST_IDLE, ST_DECIDE, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			rd_pend_q  <= 1'b0;
			sh_q       <= '0;
			sh_pend_q  <= 1'b0;
			found_q    <= 1'b0;
			full_q     <= 1'b0;
			ins_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// taken result drops unless a new one is loaded this cycle
			if (m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						pos_q     <= '0;
						rd_pend_q <= 1'b0;
						found_q   <= 1'b0;
						full_q    <= 1'b0;
						ins_q     <= 1'b0;
						state_q   <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (!rd_pend_q) begin
						if (count_q == '0) begin
							state_q <= ST_DECIDE;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else if (key_greater) begin
						pos_q <= CNT_W'(nxt_pos);
						if (!more_left) begin
							rd_pend_q <= 1'b0;
							state_q   <= ST_DECIDE;
						end
					end else begin
						// first entry not less than the value
						found_q   <= (rd_data == value_q);
						rd_pend_q <= 1'b0;
						state_q   <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (found_q) begin
						state_q <= ST_DONE;
					end else if (count_q == CAP_C) begin
						full_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						sh_q      <= count_q;
						sh_pend_q <= 1'b0;
						state_q   <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (sh_q > pos_q) begin
						sh_q      <= sh_q - 1'b1;
						sh_pend_q <= 1'b1;
					end else begin
						sh_pend_q <= 1'b0;
						state_q   <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					count_q <= count_q + 1'b1;
					ins_q   <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			value_q <= s_tdata;
		end
		if (state_q == ST_SHIFT && sh_q > pos_q) begin
			wr_idx_s1 <= IDX_W'(sh_q);
		end
		if (out_load) begin
			m_tdata_q <= {6'b0, STSI_POS_W'(count_q), STSI_POS_W'(pos_q)};
			m_tuser_q <= {full_q, ins_q, found_q};
		end
	end

endmodule

// ----- hw/rtl/stsi_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stsi_ram
// Table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module stsi_ram import stsi_pkg::*; #(
	parameter int DEPTH  = STSI_CAPACITY,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   rd_en,
	input  logic [ADDR_W-1:0]      rd_addr,
	output logic [STSI_DATA_W-1:0] rd_data,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  logic [STSI_DATA_W-1:0] wr_data
);

	logic [STSI_DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/stsi_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stsi_checker
// Port-level checks for the sorted table search/insert block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stsi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result stays offered
	`ASSERT_PROP(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

	// a stalled result keeps its payload
	`ASSERT_PROP(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// found, inserted and table_full exclude each other
	`ASSERT_ALWAYS(a_flags_excl, !m_tvalid || $onehot0(m_tuser), "conflicting result flags")

	// one request in flight: no request taken right after another
	`ASSERT_PROP(a_one_inflight, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

endmodule

bind sorted_table_search_insert stsi_checker u_stsi_checker (.*);

// ----- dv/sorted_table_search_insert_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_table_search_insert_tb
// Self-checking bench for the sorted table search/insert block.
// ---------------------------------------------------------------------------
// A shadow copy of the table predicts each response: the first entry not
// less than the value gives the position, and the outcome is found, table
// full or an ordered insert. A directed sequence fills the table from empty
// and then hits both ends and the middle. After that, random lookups aimed at
// stored entries, their neighbours, the extremes and arbitrary words run
// against the full table. Random gaps on the request side and random stalls
// on the response side shift the handshakes across every phase of the scan
// and shift work.
// ---------------------------------------------------------------------------
import stsi_pkg::*;

// expected response of one lookup
typedef struct packed {
	logic                  found;
	logic [STSI_POS_W-1:0] position;
	logic                  inserted;
	logic                  table_full;
	logic [STSI_POS_W-1:0] fill_count;
} lookup_result_t;

// shadow of the table contents plus the responses still owed by the block
class table_shadow;
	logic signed [STSI_DATA_W-1:0] entries[$];
	lookup_result_t                awaited_results[$];
	int                            mismatches = 0;

	function int count();
		return entries.size();
	endfunction

	function logic [STSI_DATA_W-1:0] entry(int idx);
		return entries[idx];
	endfunction

	function int pending();
		return awaited_results.size();
	endfunction

	// accepted request: search, then insert if absent and room is left
	function void note_request(logic signed [STSI_DATA_W-1:0] value);
		lookup_result_t r;
		int             pos;
		int             n;
		r   = '0;
		pos = 0;
		while (pos < entries.size() && value > entries[pos])
			pos++;
		if (pos < entries.size() && entries[pos] == value) begin
			r.found = 1'b1;
		end else if (entries.size() >= STSI_CAPACITY) begin
			r.table_full = 1'b1;
		end else begin
			entries.insert(pos, value);
			r.inserted = 1'b1;
		end
		r.position   = pos[STSI_POS_W-1:0];
		n            = entries.size();
		r.fill_count = n[STSI_POS_W-1:0];
		awaited_results.push_back(r);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// accepted response against the oldest expectation
	function void check_result(logic [15:0] tdata, logic [2:0] tuser);
		lookup_result_t want;
		if (awaited_results.size() == 0) begin
			$error("response with no request outstanding: tdata %h, tuser %b",
				tdata, tuser);
			mismatches++;
			return;
		end
		want = awaited_results.pop_front();
		compare_field("found", 8'(want.found), 8'(tuser[0]));
		compare_field("inserted", 8'(want.inserted), 8'(tuser[1]));
		compare_field("table_full", 8'(want.table_full), 8'(tuser[2]));
		compare_field("position", 8'(want.position), 8'(tdata[4:0]));
		compare_field("fill_count", 8'(want.fill_count), 8'(tdata[9:5]));
	endfunction
endclass

module sorted_table_search_insert_tb;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1650;
	// longest request: full scan plus full shift, with margin
	localparam int DRAIN_CYCLES = 2 * STSI_CAPACITY + 8;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;

	table_shadow shadow;
	bit          steady = 1'b0;
	int          cycle_count = 0;

	// fill from empty, then full-table cases at both ends and the middle
	logic [31:0] directed_values [25] = '{
		32'd0, 32'd1000, -32'sd1000, 32'd0, -32'sd1000, 32'd1000,
		32'd500, 32'hFFFF_FFFF, 32'h7FFF_FFF0, 32'h8000_0010, 32'd7,
		-32'sd7, 32'h1234_5678, 32'hEDCB_A988, 32'h4000_0000,
		32'hC000_0000, 32'd2, -32'sd2, 32'd3,
		32'h8000_0000, 32'h7FFF_FFFF, 32'd4,
		32'h8000_0010, 32'h7FFF_FFF0, -32'sd7
	};

	sorted_table_search_insert #(
		.CAPACITY(STSI_CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// lookup values aimed at stored entries, their neighbours, the extremes and arbitrary words
	function automatic logic [31:0] random_value();
		int          sel;
		logic [31:0] base;
		logic [31:0] delta;
		sel   = $urandom_range(0, 99);
		base  = shadow.entry($urandom_range(0, shadow.count() - 1));
		delta = $urandom_range(0, 6);
		if (sel < 45)
			return base;
		if (sel < 70)
			return base + delta - 32'd3;
		if (sel < 80) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	// one request, held until the block takes it
	task automatic send_value(input logic [31:0] value);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom();
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		shadow.note_request(value);
	endtask

	// response side back-pressure
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			stall = idle_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			shadow.check_result(m_tdata, m_tuser);
	end

	// stimulus and end of run
	initial begin
		shadow = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			send_value(directed_values[i]);

		// random lookups, with bursts free of any idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n % 400) < 50;
			send_value(random_value());
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (shadow.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (shadow.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
